// ===== src/depth_normal_to_plane_macros.svh =====
// Assertion macros for the depth-to-plane pipeline.
// Needs clk and rst in the scope of the module that uses them.
`ifndef DEPTH_NORMAL_TO_PLANE_MACROS_SVH
`define DEPTH_NORMAL_TO_PLANE_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define DNP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define DNP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dnp_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the depth-to-plane pipeline: register indexes,
// fixed field widths and stage counts. No dependencies.
package dnp_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int CENTER_W       = 28;
  localparam int DEPTH_W        = 41;
  localparam int OFF_W          = 48;

  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd5;

  localparam logic [15:0] NORM_ZERO_CODE = 16'h8000;

  // One root bit per stage: 31 bits of root for a 62-bit radicand.
  localparam int SQRT_STEPS = 31;
  // One quotient bit per stage; the quotient never reaches 2^17.
  localparam int DIV_STEPS  = 17;

  // Split of the final depth x |t| product into partial products.
  localparam int DL_W = 21;
  localparam int TL_W = 29;

  // Rounding and saturation points of the offset.
  localparam int OFF_SHIFT = 39;
  localparam int SAT_BIT   = 86;

  localparam logic [OFF_W-1:0] OFF_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [OFF_W-1:0] OFF_MIN = 48'h8000_0000_0000;

endpackage

// ===== src/depth_normal_to_plane.sv =====
`timescale 1ns / 1ps
// Depth-to-plane pipeline: one pixel of depth and normal in, one plane out.
// Depends on dnp_pkg and depth_normal_to_plane_macros.svh.
//
//  channel  | signals                                        | dir | transfer
//  ---------+------------------------------------------------+-----+-------------------
//  input    | in_valid, in_ready, raw_depth, normal_*_code,  | in  | valid & ready
//           | pixel_col, pixel_row                           |     |
//  output   | out_valid, out_ready, plane_n*, plane_offset,  | out | valid & ready
//           | degenerate                                     |     |
//  config   | cfg_wen, cfg_index, cfg_wdata                  | in  | cfg_wen, no wait
//
// One item may enter every cycle while the output is not stalled. Most of
// the pipeline is the 31-stage square-root chain and the
// 17-stage divider, each resolving one bit per stage.
// Reset is synchronous and clears only the valid bits and registers.
// On an output stall, empty stages keep filling from the back, so the block
// keeps taking items until every stage holds one; nothing is dropped.
`include "depth_normal_to_plane_macros.svh"

module depth_normal_to_plane
  import dnp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [15:0]                  raw_depth,
  input  logic [15:0]                  normal_x_code,
  input  logic [15:0]                  normal_y_code,
  input  logic [15:0]                  normal_z_code,
  input  logic [COORD_BITS-1:0]        pixel_col,
  input  logic [COORD_BITS-1:0]        pixel_row,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [15:0]           plane_nx,
  output logic signed [15:0]           plane_ny,
  output logic signed [15:0]           plane_nz,
  output logic signed [OFF_W-1:0]      plane_offset,
  output logic                         degenerate
);

  // Derived widths: coordinate difference, ray slope, dot products, product.
  localparam int DIFF_W = ((COORD_BITS + 16) > CENTER_W ? (COORD_BITS + 16) : CENTER_W) + 1;
  localparam int MAG_W  = DIFF_W - 1;
  localparam int PRD_W  = MAG_W + 33;
  localparam int SLP_W  = PRD_W - 24;
  localparam int AX_W   = SLP_W + 1;
  localparam int NA_W   = AX_W + 16;
  localparam int T_W    = AX_W + 18;
  localparam int TH_W   = T_W - TL_W;
  localparam int DH_W   = DEPTH_W - DL_W;
  localparam int P_W    = DEPTH_W + T_W;
  localparam int R_W    = P_W + 1;

  // Stage map.
  localparam int SQ_BASE = 6;
  localparam int PR_STG  = SQ_BASE + SQRT_STEPS;
  localparam int DV_BASE = PR_STG + 1;
  localparam int U_STG   = DV_BASE + DIV_STEPS;
  localparam int M_STG   = U_STG + 1;
  localparam int T_STG   = M_STG + 1;
  localparam int G_STG   = T_STG + 1;
  localparam int P_STG   = G_STG + 1;
  localparam int S_STG   = P_STG + 1;
  localparam int O_STG   = S_STG + 1;
  localparam int NS      = O_STG + 1;

  typedef struct packed {
    logic                       deg;
    logic [2:0]                 neg;
    logic [2:0][15:0]           mag;
    logic [DEPTH_W-1:0]         depth;
    logic [AX_W-1:0]            ax;
    logic [AX_W-1:0]            ay;
  } ctx_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0]         reg_depth_min;
  logic [31:0]         reg_depth_step;
  logic [31:0]         reg_inv_focal_x;
  logic [31:0]         reg_inv_focal_y;
  logic [CENTER_W-1:0] reg_center_x;
  logic [CENTER_W-1:0] reg_center_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_depth_min   <= '0;
      reg_depth_step  <= '0;
      reg_inv_focal_x <= '0;
      reg_inv_focal_y <= '0;
      reg_center_x    <= '0;
      reg_center_y    <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_DEPTH_MIN:   reg_depth_min   <= cfg_wdata;
        REG_DEPTH_STEP:  reg_depth_step  <= cfg_wdata;
        REG_INV_FOCAL_X: reg_inv_focal_x <= cfg_wdata;
        REG_INV_FOCAL_Y: reg_inv_focal_y <= cfg_wdata;
        REG_CENTER_X:    reg_center_x    <= cfg_wdata[CENTER_W-1:0];
        REG_CENTER_Y:    reg_center_y    <= cfg_wdata[CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: a stage loads when the pipe advances or when it is
  // empty, so bubbles close up behind a stalled output.
  // ---------------------------------------------------------------------------
  logic [NS-1:0] vld;
  logic [NS-1:0] vld_next;
  logic [NS-1:0] en;
  logic          advance;
  logic          in_fire;
  logic          out_fire;

  assign advance  = ~vld[NS-1] | out_ready;
  assign in_ready = ~rst & en[0];
  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid & out_ready;

  always_comb begin
    for (int k = 0; k < NS - 1; k++) begin
      en[k] = advance | ~vld[k];
    end
    en[NS-1] = advance;
  end

  always_comb begin
    vld_next[0] = en[0] ? in_valid : (en[1] ? 1'b0 : vld[0]);
    for (int k = 1; k < NS - 1; k++) begin
      vld_next[k] = en[k] ? vld[k-1] : (en[k+1] ? 1'b0 : vld[k]);
    end
    vld_next[NS-1] = en[NS-1] ? vld[NS-2] : vld[NS-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: decode normals, depth product, coordinate differences
  // ---------------------------------------------------------------------------
  logic [15:0] codes [3];
  assign codes[0] = normal_x_code;
  assign codes[1] = normal_y_code;
  assign codes[2] = normal_z_code;

  logic [47:0]              a_prod;
  logic signed [DIFF_W-1:0] a_dx, a_dy;
  logic signed [15:0]       a_n [3];
  logic [2:0][15:0]         a_mag;
  logic [2:0]               a_ns;
  logic                     a_deg;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_prod <= raw_depth * reg_depth_step;
      a_dx   <= DIFF_W'({pixel_col, 16'b0}) - DIFF_W'(reg_center_x);
      a_dy   <= DIFF_W'({pixel_row, 16'b0}) - DIFF_W'(reg_center_y);
      for (int i = 0; i < 3; i++) begin
        a_n[i]   <= {~codes[i][15], codes[i][14:0]};
        a_mag[i] <= codes[i][15] ? {1'b0, codes[i][14:0]} : 16'(16'h8000 - codes[i]);
        a_ns[i]  <= ~codes[i][15];
      end
      a_deg <= (normal_x_code == NORM_ZERO_CODE) && (normal_y_code == NORM_ZERO_CODE) &&
               (normal_z_code == NORM_ZERO_CODE);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: depth, coordinate magnitudes
  // ---------------------------------------------------------------------------
  logic [DEPTH_W-1:0] b_depth;
  logic [MAG_W-1:0]   b_mx, b_my;
  logic               b_sx, b_sy;
  logic signed [15:0] b_n [3];
  logic [2:0][15:0]   b_mag;
  logic [2:0]         b_ns;
  logic               b_deg;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      b_depth <= DEPTH_W'(reg_depth_min) + DEPTH_W'((a_prod + 48'd128) >> 8);
      b_mx    <= a_dx[DIFF_W-1] ? MAG_W'(-a_dx) : MAG_W'(a_dx);
      b_my    <= a_dy[DIFF_W-1] ? MAG_W'(-a_dy) : MAG_W'(a_dy);
      b_sx    <= a_dx[DIFF_W-1];
      b_sy    <= a_dy[DIFF_W-1];
      b_n     <= a_n;
      b_mag   <= a_mag;
      b_ns    <= a_ns;
      b_deg   <= a_deg;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: scale by inverse focal lengths
  // ---------------------------------------------------------------------------
  logic [PRD_W-1:0]   c_px, c_py;
  logic               c_sx, c_sy;
  logic [DEPTH_W-1:0] c_depth;
  logic signed [15:0] c_n [3];
  logic [2:0][15:0]   c_mag;
  logic [2:0]         c_ns;
  logic               c_deg;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c_px    <= PRD_W'(b_mx) * PRD_W'(reg_inv_focal_x);
      c_py    <= PRD_W'(b_my) * PRD_W'(reg_inv_focal_y);
      c_sx    <= b_sx;
      c_sy    <= b_sy;
      c_depth <= b_depth;
      c_n     <= b_n;
      c_mag   <= b_mag;
      c_ns    <= b_ns;
      c_deg   <= b_deg;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: round to Q.24 ray slopes, restore sign
  // ---------------------------------------------------------------------------
  logic [SLP_W-1:0]       d_mx, d_my;
  logic signed [AX_W-1:0] d_ax, d_ay;
  logic [DEPTH_W-1:0]     d_depth;
  logic signed [15:0]     d_n [3];
  logic [2:0][15:0]       d_mag;
  logic [2:0]             d_ns;
  logic                   d_deg;

  assign d_mx = SLP_W'((c_px + (PRD_W'(1) << 23)) >> 24);
  assign d_my = SLP_W'((c_py + (PRD_W'(1) << 23)) >> 24);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      d_ax    <= c_sx ? -AX_W'(d_mx) : AX_W'(d_mx);
      d_ay    <= c_sy ? -AX_W'(d_my) : AX_W'(d_my);
      d_depth <= c_depth;
      d_n     <= c_n;
      d_mag   <= c_mag;
      d_ns    <= c_ns;
      d_deg   <= c_deg;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E: facing products and squared components
  // ---------------------------------------------------------------------------
  logic signed [NA_W-1:0] e_nax, e_nay;
  logic signed [15:0]     e_nz;
  logic [31:0]            e_sq [3];
  logic [DEPTH_W-1:0]     e_depth;
  logic signed [AX_W-1:0] e_ax, e_ay;
  logic [2:0][15:0]       e_mag;
  logic [2:0]             e_ns;
  logic                   e_deg;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      e_nax   <= NA_W'(d_n[0]) * NA_W'(d_ax);
      e_nay   <= NA_W'(d_n[1]) * NA_W'(d_ay);
      e_nz    <= d_n[2];
      for (int i = 0; i < 3; i++) begin
        e_sq[i] <= d_mag[i] * d_mag[i];
      end
      e_depth <= d_depth;
      e_ax    <= d_ax;
      e_ay    <= d_ay;
      e_mag   <= d_mag;
      e_ns    <= d_ns;
      e_deg   <= d_deg;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage F: facing sum and squared length
  // ---------------------------------------------------------------------------
  logic signed [T_W-1:0]  f_s;
  logic [31:0]            f_sq;
  logic [DEPTH_W-1:0]     f_depth;
  logic signed [AX_W-1:0] f_ax, f_ay;
  logic [2:0][15:0]       f_mag;
  logic [2:0]             f_ns;
  logic                   f_deg;
  logic                   f_flip;
  ctx_t                   f_ctx;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      f_s     <= T_W'(e_nax) + T_W'(e_nay) + (T_W'(e_nz) << 24);
      f_sq    <= e_sq[0] + e_sq[1] + e_sq[2];
      f_depth <= e_depth;
      f_ax    <= e_ax;
      f_ay    <= e_ay;
      f_mag   <= e_mag;
      f_ns    <= e_ns;
      f_deg   <= e_deg;
    end
  end

  // Flip a normal that faces along the view ray; never with zero depth.
  assign f_flip = (f_depth != '0) && !f_s[T_W-1] && (f_s != '0);

  always_comb begin
    f_ctx.deg   = f_deg;
    f_ctx.neg   = f_ns ^ {3{f_flip}};
    f_ctx.mag   = f_mag;
    f_ctx.depth = f_depth;
    f_ctx.ax    = f_ax;
    f_ctx.ay    = f_ay;
  end

  // ---------------------------------------------------------------------------
  // Square root of |n|^2 * 2^30, one root bit per stage
  // ---------------------------------------------------------------------------
  logic [33:0] sq_rem  [SQRT_STEPS];
  logic [30:0] sq_root [SQRT_STEPS];
  logic [31:0] sq_rad  [SQRT_STEPS];
  ctx_t        sq_ctx  [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    logic [33:0] rem_in;
    logic [30:0] root_in;
    logic [31:0] rad_in;
    ctx_t        ctx_in;
    logic [35:0] rem_sh;
    logic [35:0] trial;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = f_sq;
      assign ctx_in  = f_ctx;
    end else begin : g_rest
      assign rem_in  = sq_rem[j-1];
      assign root_in = sq_root[j-1];
      assign rad_in  = sq_rad[j-1];
      assign ctx_in  = sq_ctx[j-1];
    end

    assign rem_sh = {rem_in, rad_in[31:30]};
    assign trial  = {3'b000, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en[SQ_BASE + j]) begin
        if (rem_sh >= trial) begin
          sq_rem[j]  <= 34'(rem_sh - trial);
          sq_root[j] <= {root_in[29:0], 1'b1};
        end else begin
          sq_rem[j]  <= rem_sh[33:0];
          sq_root[j] <= {root_in[29:0], 1'b0};
        end
        sq_rad[j] <= {rad_in[29:0], 2'b00};
        sq_ctx[j] <= ctx_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Dividend set-up: |n_i| * 2^30 + r/2
  // ---------------------------------------------------------------------------
  logic [45:0] pr_d [3];
  logic [30:0] pr_r;
  ctx_t        pr_ctx;

  always_ff @(posedge clk) begin
    if (en[PR_STG]) begin
      for (int i = 0; i < 3; i++) begin
        pr_d[i] <= {sq_ctx[SQRT_STEPS-1].mag[i], 30'b0} +
                   46'(sq_root[SQRT_STEPS-1] >> 1);
      end
      pr_r   <= sq_root[SQRT_STEPS-1];
      pr_ctx <= sq_ctx[SQRT_STEPS-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring division, one quotient bit per stage for all three components
  // ---------------------------------------------------------------------------
  logic [30:0] dv_rem [DIV_STEPS][3];
  logic [16:0] dv_low [DIV_STEPS][3];
  logic [16:0] dv_quo [DIV_STEPS][3];
  logic [30:0] dv_r   [DIV_STEPS];
  ctx_t        dv_ctx [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [30:0] rem_in [3];
    logic [16:0] low_in [3];
    logic [16:0] quo_in [3];
    logic [30:0] r_in;
    ctx_t        ctx_in;
    logic [31:0] rsh [3];
    logic [31:0] dvs;

    if (j == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = 31'(pr_d[i][45:17]);
          low_in[i] = pr_d[i][16:0];
          quo_in[i] = '0;
        end
      end
      assign r_in   = pr_r;
      assign ctx_in = pr_ctx;
    end else begin : g_rest
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = dv_rem[j-1][i];
          low_in[i] = dv_low[j-1][i];
          quo_in[i] = dv_quo[j-1][i];
        end
      end
      assign r_in   = dv_r[j-1];
      assign ctx_in = dv_ctx[j-1];
    end

    assign dvs = {1'b0, r_in};

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rsh[i] = {rem_in[i], low_in[i][16]};
      end
    end

    always_ff @(posedge clk) begin
      if (en[DV_BASE + j]) begin
        for (int i = 0; i < 3; i++) begin
          if (rsh[i] >= dvs) begin
            dv_rem[j][i] <= 31'(rsh[i] - dvs);
            dv_quo[j][i] <= {quo_in[i][15:0], 1'b1};
          end else begin
            dv_rem[j][i] <= rsh[i][30:0];
            dv_quo[j][i] <= {quo_in[i][15:0], 1'b0};
          end
          dv_low[j][i] <= {low_in[i][15:0], 1'b0};
        end
        dv_r[j]   <= r_in;
        dv_ctx[j] <= ctx_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage U: signed, saturated unit normal
  // ---------------------------------------------------------------------------
  logic signed [15:0]     u_next [3];
  logic signed [15:0]     u_u [3];
  logic [DEPTH_W-1:0]     u_depth;
  logic signed [AX_W-1:0] u_ax, u_ay;
  logic                   u_deg;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_ctx[DIV_STEPS-1].neg[i]) begin
        u_next[i] = (dv_quo[DIV_STEPS-1][i] > 17'd32768) ? 16'sh8000 :
                    16'(17'd0 - dv_quo[DIV_STEPS-1][i]);
      end else begin
        u_next[i] = (dv_quo[DIV_STEPS-1][i] > 17'd32767) ? 16'sh7FFF :
                    dv_quo[DIV_STEPS-1][i][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[U_STG]) begin
      u_u     <= u_next;
      u_depth <= dv_ctx[DIV_STEPS-1].depth;
      u_ax    <= dv_ctx[DIV_STEPS-1].ax;
      u_ay    <= dv_ctx[DIV_STEPS-1].ay;
      u_deg   <= dv_ctx[DIV_STEPS-1].deg;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage M: unit normal times ray slopes
  // ---------------------------------------------------------------------------
  logic signed [NA_W-1:0] m_a, m_b;
  logic signed [15:0]     m_u [3];
  logic [DEPTH_W-1:0]     m_depth;
  logic                   m_deg;

  always_ff @(posedge clk) begin
    if (en[M_STG]) begin
      m_a     <= NA_W'(u_u[0]) * NA_W'(u_ax);
      m_b     <= NA_W'(u_u[1]) * NA_W'(u_ay);
      m_u     <= u_u;
      m_depth <= u_depth;
      m_deg   <= u_deg;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage T: dot product of unit normal and ray
  // ---------------------------------------------------------------------------
  logic signed [T_W-1:0] t_t;
  logic signed [15:0]    t_u [3];
  logic [DEPTH_W-1:0]    t_depth;
  logic                  t_deg;

  always_ff @(posedge clk) begin
    if (en[T_STG]) begin
      t_t     <= T_W'(m_a) + T_W'(m_b) + (T_W'(m_u[2]) << 24);
      t_u     <= m_u;
      t_depth <= m_depth;
      t_deg   <= m_deg;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage G: sign and magnitude of the dot product
  // ---------------------------------------------------------------------------
  logic [T_W-1:0]     g_mag;
  logic               g_neg;
  logic signed [15:0] g_u [3];
  logic [DEPTH_W-1:0] g_depth;
  logic               g_deg;

  always_ff @(posedge clk) begin
    if (en[G_STG]) begin
      g_neg   <= t_t[T_W-1];
      g_mag   <= t_t[T_W-1] ? T_W'(-t_t) : T_W'(t_t);
      g_u     <= t_u;
      g_depth <= t_depth;
      g_deg   <= t_deg;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage P: four partial products of depth x |t|
  // ---------------------------------------------------------------------------
  logic [DL_W+TL_W-1:0] p_ll;
  logic [DL_W+TH_W-1:0] p_lh;
  logic [DH_W+TL_W-1:0] p_hl;
  logic [DH_W+TH_W-1:0] p_hh;
  logic                 p_neg;
  logic signed [15:0]   p_u [3];
  logic                 p_deg;

  always_ff @(posedge clk) begin
    if (en[P_STG]) begin
      p_ll  <= g_depth[DL_W-1:0]       * g_mag[TL_W-1:0];
      p_lh  <= g_depth[DL_W-1:0]       * g_mag[T_W-1:TL_W];
      p_hl  <= g_depth[DEPTH_W-1:DL_W] * g_mag[TL_W-1:0];
      p_hh  <= g_depth[DEPTH_W-1:DL_W] * g_mag[T_W-1:TL_W];
      p_neg <= g_neg;
      p_u   <= g_u;
      p_deg <= g_deg;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage S: combine partials and add the rounding half
  // ---------------------------------------------------------------------------
  logic [R_W-1:0]     s_r;
  logic               s_neg;
  logic signed [15:0] s_u [3];
  logic               s_deg;

  always_ff @(posedge clk) begin
    if (en[S_STG]) begin
      s_r   <= R_W'(p_ll) + (R_W'(p_lh) << TL_W) + (R_W'(p_hl) << DL_W) +
               (R_W'(p_hh) << (TL_W + DL_W)) + (R_W'(1) << (OFF_SHIFT - 1));
      s_neg <= p_neg;
      s_u   <= p_u;
      s_deg <= p_deg;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage O: saturate and negate the offset, zero degenerate items
  // ---------------------------------------------------------------------------
  logic [OFF_W-2:0]   s_mag;
  logic               s_sat;
  logic [OFF_W-1:0]   s_off;
  logic signed [15:0] o_u [3];
  logic [OFF_W-1:0]   o_off;
  logic               o_deg;

  assign s_mag = s_r[SAT_BIT-1:OFF_SHIFT];
  assign s_sat = |s_r[R_W-1:SAT_BIT];

  always_comb begin
    if (s_sat) begin
      s_off = s_neg ? OFF_MAX : OFF_MIN;
    end else if (s_neg) begin
      s_off = {1'b0, s_mag};
    end else begin
      s_off = OFF_W'(0) - {1'b0, s_mag};
    end
  end

  always_ff @(posedge clk) begin
    if (en[O_STG]) begin
      for (int i = 0; i < 3; i++) begin
        o_u[i] <= s_deg ? 16'sd0 : s_u[i];
      end
      o_off <= s_deg ? '0 : s_off;
      o_deg <= s_deg;
    end
  end

  assign out_valid    = vld[NS-1];
  assign plane_nx     = o_u[0];
  assign plane_ny     = o_u[1];
  assign plane_nz     = o_u[2];
  assign plane_offset = o_off;
  assign degenerate   = o_deg;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `DNP_ASSERT_NEXT(a_item_count, 1'b1,
    $countones(vld) == $past($countones(vld)) + $past(in_fire) - $past(out_fire),
    "pipeline lost or duplicated an item")

  `DNP_ASSERT_NOW(a_deg_zero, out_valid && degenerate,
    plane_nx == 0 && plane_ny == 0 && plane_nz == 0 && plane_offset == 0,
    "degenerate item with nonzero plane")

  `DNP_ASSERT_NOW(a_unit_nonzero, out_valid && !degenerate,
    plane_nx != 0 || plane_ny != 0 || plane_nz != 0,
    "unit normal collapsed to zero")

endmodule

// ===== verif/depth_normal_to_plane_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for depth_normal_to_plane: a directed table, then random pixels
// under several register settings and flow-control patterns. Depends on dnp_pkg and depth_normal_to_plane.
module depth_normal_to_plane_tb;
  import dnp_pkg::*;

  localparam int CBITS      = COORD_BITS_DEF;
  localparam int DRAIN_CYC  = 80;      // a little over the pipeline depth
  localparam int RAND_PER   = 144;     // random items per phase, 8 phases
  localparam int CYCLE_CAP  = 600000;

  // Flow-control patterns, as percentages of cycles spent idle or stalled
  typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH} flow_e;

  typedef struct {
    logic [15:0]      raw;
    logic [15:0]      ncx, ncy, ncz;
    logic [CBITS-1:0] col, row;
  } pixel_t;

  typedef struct {
    logic signed [15:0]      nx, ny, nz;
    logic signed [OFF_W-1:0] off;
    logic                    deg;
  } plane_t;

  typedef struct {
    pixel_t pix;
    bit     typed;   // expected plane written out by hand (reset registers only)
    plane_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] raw_depth = '0, normal_x_code = '0, normal_y_code = '0, normal_z_code = '0;
  logic [CBITS-1:0] pixel_col = '0, pixel_row = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] plane_nx, plane_ny, plane_nz;
  logic signed [OFF_W-1:0] plane_offset;
  logic degenerate;

  depth_normal_to_plane i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bench copy of the registers, updated as each write goes out
  logic [31:0] cur_dmin = 0, cur_dstep = 0, cur_ifx = 0, cur_ify = 0;
  logic [27:0] cur_cx = 0, cur_cy = 0;

  plane_t planes_due[$];
  int     src_idle_pct = 0, snk_stall_pct = 0;
  int     n_err = 0, n_seen = 0, n_sent = 0, n_deg = 0, n_sat = 0;
  int     cycles = 0;

  // ---------------------------------------------------------------------------
  // Plane predictor
  // ---------------------------------------------------------------------------
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Signed Q.16 pixel offset from the principal point, scaled to a Q.24 slope
  function automatic longint slope_q24(longint unsigned coord, longint unsigned ctr,
                                       longint unsigned inv_f);
    longint diff = longint'(coord << 16) - longint'(ctr);
    longint unsigned mag = (diff < 0) ? longint'(-diff) : diff;
    longint unsigned m = (mag * inv_f + (64'h1 << 23)) >> 24;
    return (diff < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic signed [15:0] unit_q15(longint n, longint unsigned len);
    longint unsigned mag = (n < 0) ? longint'(-n) : n;
    longint unsigned q = ((mag << 30) + (len >> 1)) / len;
    if (n < 0) return (q > 32768) ? -16'sd32768 : 16'(-longint'(q));
    return (q > 32767) ? 16'sd32767 : 16'(q);
  endfunction

  function automatic plane_t plane_of(pixel_t p);
    plane_t r;
    longint n[3];
    logic signed [15:0] u[3];
    longint unsigned depth, sq, len, tmag, pmag;
    longint ax, ay, s, t;
    logic [127:0] prod;
    n[0] = longint'(p.ncx) - 32768;
    n[1] = longint'(p.ncy) - 32768;
    n[2] = longint'(p.ncz) - 32768;
    r = '{nx: 0, ny: 0, nz: 0, off: 0, deg: 1'b1};
    if (n[0] == 0 && n[1] == 0 && n[2] == 0) return r;
    depth = cur_dmin + ((longint'(p.raw) * cur_dstep + 128) >> 8);
    ax = slope_q24(p.col, cur_cx, cur_ifx);
    ay = slope_q24(p.row, cur_cy, cur_ify);
    s = n[0] * ax + n[1] * ay + n[2] * (64'sd1 <<< 24);
    // Turn the normal to face the camera; no ray exists at zero depth
    if (depth != 0 && s > 0) foreach (n[i]) n[i] = -n[i];
    sq = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
    len = root_floor(sq << 30);
    foreach (u[i]) u[i] = unit_q15(n[i], len);
    t = longint'(u[0]) * ax + longint'(u[1]) * ay + longint'(u[2]) * (64'sd1 <<< 24);
    tmag = (t < 0) ? longint'(-t) : t;
    prod = 128'(depth) * 128'(tmag) + (128'h1 << 38);
    if (prod[127:86] != 0) begin
      r.off = (t < 0) ? OFF_MAX : OFF_MIN;
    end else begin
      pmag = prod[85:39];
      r.off = (t < 0) ? OFF_W'(pmag) : OFF_W'(-longint'(pmag));
    end
    r.nx = u[0]; r.ny = u[1]; r.nz = u[2]; r.deg = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Register writes and item driving (inputs move on the falling edge)
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_wen = 1'b1; cfg_index = idx; cfg_wdata = val;
    case (idx)
      REG_DEPTH_MIN:   cur_dmin  = val;
      REG_DEPTH_STEP:  cur_dstep = val;
      REG_INV_FOCAL_X: cur_ifx   = val;
      REG_INV_FOCAL_Y: cur_ify   = val;
      REG_CENTER_X:    cur_cx    = val[27:0];
      REG_CENTER_Y:    cur_cy    = val[27:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wen = 1'b0;
  endtask

  task automatic load_regs(logic [31:0] dmin, dstep, ifx, ify, cx, cy);
    write_reg(REG_DEPTH_MIN, dmin);
    write_reg(REG_DEPTH_STEP, dstep);
    write_reg(REG_INV_FOCAL_X, ifx);
    write_reg(REG_INV_FOCAL_Y, ify);
    write_reg(REG_CENTER_X, cx & 32'h0FFF_FFFF);
    write_reg(REG_CENTER_Y, cy & 32'h0FFF_FFFF);
  endtask

  // Offer one item, idling beforehand as the flow pattern asks, and hold it
  // until the block takes it. The expectation is queued at the accepting edge.
  task automatic send_pixel(pixel_t p, bit typed, plane_t want);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    raw_depth = p.raw;
    normal_x_code = p.ncx; normal_y_code = p.ncy; normal_z_code = p.ncz;
    pixel_col = p.col; pixel_row = p.row;
    do @(posedge clk); while (!in_ready);
    planes_due.push_back(typed ? want : plane_of(p));
    n_sent++;
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_valid = 1'b0;
    while (planes_due.size() != 0) @(posedge clk);
    // nothing left to wait for, but let the pipe fully empty before a write
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  function automatic logic [15:0] normal_code();
    case ($urandom_range(9))
      0: return NORM_ZERO_CODE;
      1: return NORM_ZERO_CODE + 16'($urandom_range(8)) - 16'd4;   // near zero
      2: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    case ($urandom_range(15))
      0: p.raw = 16'h0000;
      1: p.raw = 16'hFFFF;
      default: p.raw = 16'($urandom);
    endcase
    if ($urandom_range(19) == 0) begin
      p.ncx = NORM_ZERO_CODE; p.ncy = NORM_ZERO_CODE; p.ncz = NORM_ZERO_CODE;
    end else begin
      p.ncx = normal_code(); p.ncy = normal_code(); p.ncz = normal_code();
    end
    p.col = CBITS'($urandom);
    p.row = CBITS'($urandom);
    return p;
  endfunction

  function automatic void set_flow(flow_e f);
    src_idle_pct  = (f == FLOW_SRC_IDLE) ? 56 : (f == FLOW_BOTH) ? 32 : 0;
    snk_stall_pct = (f == FLOW_SNK_STALL) ? 56 : (f == FLOW_BOTH) ? 32 : 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------
  always @(negedge clk)
    if (!rst) out_ready = ($urandom_range(99) >= snk_stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: run hung after %0d cycles", $time, cycles);
      $display("tb: failure");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      plane_t w;
      n_seen++;
      if (degenerate) n_deg++;
      if (plane_offset == OFF_MAX || plane_offset == OFF_MIN) n_sat++;
      if (planes_due.size() == 0) begin
        n_err++;
        $display("%0t: unexpected plane nx=%0d ny=%0d nz=%0d off=%0d deg=%0b", $time,
                 plane_nx, plane_ny, plane_nz, plane_offset, degenerate);
      end else begin
        w = planes_due.pop_front();
        if (plane_nx !== w.nx || plane_ny !== w.ny || plane_nz !== w.nz ||
            plane_offset !== w.off || degenerate !== w.deg) begin
          n_err++;
          if (n_err <= 20)
            $display("%0t: plane mismatch expected n=(%0d,%0d,%0d) off=%0d deg=%0b, got n=(%0d,%0d,%0d) off=%0d deg=%0b",
                     $time, w.nx, w.ny, w.nz, w.off, w.deg,
                     plane_nx, plane_ny, plane_nz, plane_offset, degenerate);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Directed rows. Hand-typed planes hold with all registers at reset: depth
  // is zero, so the normal is never flipped and the offset is zero.
  row_t dir_rows[] = '{
    // zero normal: flagged, all fields zero
    '{'{16'h1234, 16'h8000, 16'h8000, 16'h8000, 12'd5, 12'd7}, 1, '{0, 0, 0, 0, 1}},
    '{'{16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 12'hFFF, 12'hFFF}, 1, '{0, 0, 0, 0, 1}},
    // axis normals: unit length is +1 or -1; +1 saturates
    '{'{16'h0000, 16'hC000, 16'h8000, 16'h8000, 12'd0, 12'd0}, 1,
      '{16'sd32767, 0, 0, 0, 0}},
    '{'{16'hFFFF, 16'h4000, 16'h8000, 16'h8000, 12'd0, 12'hFFF}, 1,
      '{-16'sd32768, 0, 0, 0, 0}},
    '{'{16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 12'hFFF, 12'd0}, 1,
      '{0, 0, 16'sd32767, 0, 0}},
    '{'{16'h0001, 16'h8000, 16'h0000, 16'h8000, 12'd1, 12'd1}, 1,
      '{0, -16'sd32768, 0, 0, 0}},
    // code extremes and tiny normals
    '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF}, 0, '{0, 0, 0, 0, 0}},
    '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 12'd0, 12'd0}, 0, '{0, 0, 0, 0, 0}},
    '{'{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 12'hFFF, 12'd0}, 0, '{0, 0, 0, 0, 0}},
    '{'{16'h8000, 16'h8001, 16'h8000, 16'h8000, 12'd320, 12'd240}, 0, '{0, 0, 0, 0, 0}},
    '{'{16'h7FFF, 16'h7FFF, 16'h8001, 16'h7FFF, 12'd0, 12'hFFF}, 0, '{0, 0, 0, 0, 0}},
    '{'{16'h4000, 16'h9000, 16'h7000, 16'h2000, 12'd640, 12'd480}, 0, '{0, 0, 0, 0, 0}},
    '{'{16'hC000, 16'h6000, 16'hA000, 16'hE000, 12'd100, 12'd900}, 0, '{0, 0, 0, 0, 0}},
    '{'{16'h0001, 16'hA5A5, 16'h5A5A, 16'h0F0F, 12'hAAA, 12'h555}, 0, '{0, 0, 0, 0, 0}}
  };

  initial begin
    flow_e  fl;
    pixel_t p;
    plane_t none;
    none = '{0, 0, 0, 0, 0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed pass on reset registers, typed planes where given
    set_flow(FLOW_FREE);
    foreach (dir_rows[i]) send_pixel(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].want);
    go_quiet();

    // Same rows again with a camera-like setup, all predicted
    load_regs(32'd32768, 32'd2432, 32'd8181000, 32'd8181000, 32'd320 << 16, 32'd240 << 16);
    foreach (dir_rows[i]) send_pixel(dir_rows[i].pix, 1'b0, none);
    go_quiet();

    // Random phases: each phase loads its own register setting and takes flow pattern ph % 4
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_regs(32'd32768, 32'd2432, 32'd8181000, 32'd7950000,
                     32'd320 << 16, 32'd240 << 16);
        1: load_regs('1, '1, '1, '1, '1, '1);   // everything at maximum
        2: load_regs(0, 0, 0, 0, 0, 0);
        4: load_regs(32'd65536, 32'd40000, 32'h4000_0000, 32'h0100_0000,
                     32'd2048 << 16, 32'd2048 << 16);
        6: load_regs('1, '1, '1, '1, 0, 0);
        default: load_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      endcase
      fl = flow_e'(ph % 4);
      set_flow(fl);
      for (int k = 0; k < RAND_PER; k++) begin
        // swing between pattern and free flow now and then for bursts
        if (k % 48 == 40) set_flow(FLOW_FREE);
        if (k % 48 == 0) set_flow(fl);
        p = random_pixel();
        send_pixel(p, 1'b0, none);
      end
      set_flow(FLOW_FREE);
      go_quiet();
    end

    $display("Sent %0d pixels over 10 register settings and 4 flow patterns;", n_sent);
    $display("checked %0d planes, %0d degenerate, %0d with saturated offset.",
             n_seen, n_deg, n_sat);
    if (n_err == 0 && planes_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d planes missing", n_err, planes_due.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
